// ===== hw/rtl/rwz_pkg.sv =====
// Package for the rolling-window z-score block: sizes, widths and op codes.
// Used by rolling_window_zscore; depends on nothing else.
`timescale 1ns / 1ps
package rwz_pkg;
  localparam int Window   = 64;
  localparam int Channels = 32;
  localparam int ChW      = 5;
  localparam int SlotW    = $clog2(Window);
  localparam int FillW    = $clog2(Window + 1);
  localparam int XW       = 24;
  localparam int SumW     = XW + SlotW;
  localparam int SqW      = 2 * XW - 1 + SlotW;
  localparam int DW       = SumW + 2;
  localparam int VW       = 2 * SumW + 2;
  localparam int RootW    = VW / 2 + 1;
  localparam int NumW     = DW + 16;
  localparam int SlotTot  = Channels * Window;
  localparam int AddrW    = $clog2(SlotTot);

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_NORM = 1'b1;

  localparam logic signed [XW-1:0] ZMax = 24'sh7FFFFF;
  localparam logic signed [XW-1:0] ZMin = -24'sh800000;
endpackage

// ===== hw/rtl/rolling_window_zscore.sv =====
// Top level of the rolling-window z-score normalizer: sample ring memory,
// per-channel sums and a sequencer around one shared add/subtract unit.
// Depends on rwz_pkg.
`timescale 1ns / 1ps
// Each channel keeps its last 64 Q8.16 samples in a ring memory plus a
// running sum and sum of squares. An add transfer reads the target slot
// from memory, waits for the registered read data, then does the update. A
// normalize transfer has a setup step, the wide products n*Q and S*S on the
// shared add/subtract unit in shift-add form one bit a cycle (up to 7 and
// 30 bits), one variance compare, 31 square-root steps and 48 divide steps,
// each phase with a closing step, then a load of the output register. A
// non-positive variance skips the root, and an empty window finishes at its
// setup step. The block takes one item at a time. A finished result sits
// in the output register, so the next item may be accepted while it waits;
// a following normalize holds in its last state until that register frees.
// No clearing pass after reset.
module rolling_window_zscore (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [rwz_pkg::ChW-1:0]       in_channel,
  input  logic signed [rwz_pkg::XW-1:0] in_sample_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rwz_pkg::ChW-1:0]       out_channel,
  output logic signed [rwz_pkg::XW-1:0] out_z_score,
  output logic                          out_variance_flag,
  output logic                          out_empty_flag
);
  localparam int XW = rwz_pkg::XW;
  localparam int VW = rwz_pkg::VW;
  localparam int DW = rwz_pkg::DW;
  localparam int RW = rwz_pkg::RootW;
  localparam int NW = rwz_pkg::NumW;
  localparam int CW = 7;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ARD  = 4'd1;
  localparam logic [3:0] S_AUPD = 4'd2;
  localparam logic [3:0] S_NQ   = 4'd3;
  localparam logic [3:0] S_SS   = 4'd4;
  localparam logic [3:0] S_VAR  = 4'd5;
  localparam logic [3:0] S_SQRT = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;
  localparam logic [3:0] S_AWAIT = 4'd9;

  logic [3:0] state_r, state_nxt;

  // Per-channel state.
  logic [rwz_pkg::FillW-1:0]        fill_r [rwz_pkg::Channels];
  logic [rwz_pkg::SlotW-1:0]        oldest_r [rwz_pkg::Channels];
  logic signed [rwz_pkg::SumW-1:0]  sum_r [rwz_pkg::Channels];
  logic [rwz_pkg::SqW-1:0]          sq_r [rwz_pkg::Channels];

  // Sample ring memory.
  logic signed [XW-1:0] ring_mem [rwz_pkg::SlotTot];
  logic signed [XW-1:0] ring_rd_r;
  logic                 ring_we;
  logic [rwz_pkg::AddrW-1:0] ring_addr;

  // Item registers.
  logic                 req_r;
  logic [rwz_pkg::ChW-1:0] ch_r;
  logic signed [XW-1:0] x_r;

  // Datapath registers.
  logic [VW-1:0]        acc_r, acc_nxt;   // shift-add accumulator / remainder
  logic [VW-1:0]        mcand_r, mcand_nxt;
  logic [VW-1:0]        mplier_r, mplier_nxt;
  logic [VW-1:0]        nq_r, nq_nxt;
  logic [RW-1:0]        root_r, root_nxt;
  logic [NW-1:0]        quo_r, quo_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic signed [DW-1:0] d_r, d_nxt;

  logic                 ov_r, ov_nxt;
  logic [rwz_pkg::ChW-1:0] oc_r;
  logic signed [XW-1:0] oz_r, oz_nxt;
  logic                 ovf_r, ovf_nxt, oef_r, oef_nxt;

  // Output register, loaded from the working result when it frees.
  logic signed [XW-1:0] res_z_r;
  logic                 res_vf_r;
  logic                 res_ef_r;

  logic ch_ok;
  logic [rwz_pkg::ChW-1:0] ci;
  logic [rwz_pkg::FillW-1:0] n_cur;
  logic signed [rwz_pkg::SumW-1:0] s_cur;
  logic [rwz_pkg::SumW-1:0] s_abs;

  // Shared add/subtract unit.
  logic [VW:0] alu_a, alu_b, alu_y;
  logic        alu_sub;

  assign alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

  assign ci    = ch_r;
  assign ch_ok = (32'(ch_r) < rwz_pkg::Channels);
  assign n_cur = fill_r[ci];
  assign s_cur = sum_r[ci];
  assign s_abs = s_cur[rwz_pkg::SumW-1] ? rwz_pkg::SumW'(-s_cur) : rwz_pkg::SumW'(s_cur);

  assign in_ready = (state_r == S_IDLE);

  // Ring address: oldest slot when full (read and overwrite), else next free.
  always_comb begin
    logic [rwz_pkg::SlotW-1:0] slot;
    slot = (32'(n_cur) >= rwz_pkg::Window) ? oldest_r[ci]
         : rwz_pkg::SlotW'(oldest_r[ci] + rwz_pkg::SlotW'(n_cur));
    ring_addr = {ch_r, slot};
  end
  assign ring_we = (state_r == S_AUPD) && ch_ok;

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_addr] <= x_r;
    end
    ring_rd_r <= ring_mem[ring_addr];
  end

  // Bit-serial shift-add / root / divide step logic.
  always_comb begin
    logic [VW-1:0] trial;
    logic [VW+1:0] rem2;
    logic [NW:0]   num;
    state_nxt  = state_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    nq_nxt     = nq_r;
    root_nxt   = root_r;
    quo_nxt    = quo_r;
    cnt_nxt    = cnt_r;
    d_nxt      = d_r;
    ov_nxt     = ov_r && !out_ready;
    oz_nxt     = oz_r;
    ovf_nxt    = ovf_r;
    oef_nxt    = oef_r;
    alu_a      = '0;
    alu_b      = '0;
    alu_sub    = 1'b0;
    trial      = '0;
    rem2       = '0;
    num        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          state_nxt = (in_req_type == rwz_pkg::REQ_ADD) ? S_ARD : S_NQ;
        end
      end
      S_ARD: state_nxt = S_AWAIT;
      S_AWAIT: state_nxt = S_AUPD;
      S_AUPD: state_nxt = S_IDLE;
      S_NQ: begin
        // First cycle: set up n*Q as shift-add over the bits of n.
        if (!ch_ok || n_cur == '0) begin
          oz_nxt = '0; ovf_nxt = 1'b0; oef_nxt = 1'b1;
          state_nxt = S_DONE;
        end else if (cnt_r == '0) begin
          acc_nxt    = '0;
          mcand_nxt  = VW'(sq_r[ci]);
          mplier_nxt = VW'(n_cur);
          d_nxt      = DW'($signed({1'b0, n_cur}) * x_r) - DW'(s_cur);
          cnt_nxt    = CW'(1);
        end else if (mplier_r == '0) begin
          nq_nxt     = acc_r;
          acc_nxt    = '0;
          mcand_nxt  = VW'(s_abs);
          mplier_nxt = VW'(s_abs);
          cnt_nxt    = '0;
          state_nxt  = S_SS;
        end else begin
          alu_a = {1'b0, acc_r};
          alu_b = {1'b0, mcand_r};
          if (mplier_r[0]) acc_nxt = alu_y[VW-1:0];
          mcand_nxt  = mcand_r << 1;
          mplier_nxt = mplier_r >> 1;
        end
      end
      S_SS: begin
        if (mplier_r == '0) begin
          state_nxt = S_VAR;
        end else begin
          alu_a = {1'b0, acc_r};
          alu_b = {1'b0, mcand_r};
          if (mplier_r[0]) acc_nxt = alu_y[VW-1:0];
          mcand_nxt  = mcand_r << 1;
          mplier_nxt = mplier_r >> 1;
        end
      end
      S_VAR: begin
        // V = nQ - SS; non-positive means stddev 1.
        alu_a = {1'b0, nq_r};
        alu_b = {1'b0, acc_r};
        alu_sub = 1'b1;
        if (alu_y[VW] || alu_y[VW-1:0] == '0) begin
          ovf_nxt = 1'b1; oef_nxt = 1'b0;
          mplier_nxt = VW'(n_cur);
          num = (NW+1)'(d_r[DW-1] ? -d_r : d_r);
          quo_nxt = NW'(num);
          cnt_nxt = CW'(NW);
          acc_nxt = '0;
          state_nxt = S_DIV;
        end else begin
          ovf_nxt = 1'b0; oef_nxt = 1'b0;
          nq_nxt  = alu_y[VW-1:0];   // V
          acc_nxt = '0;              // root remainder
          root_nxt = '0;
          // One step for each bit pair of V.
          cnt_nxt = CW'(VW / 2);
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        // Digit-by-digit root: two bits of V per step.
        if (cnt_r == '0) begin
          if (root_r == '0) root_nxt = RW'(1);
          mplier_nxt = VW'(root_r == '0 ? RW'(1) : root_r);
          num = (NW+1)'(d_r[DW-1] ? -d_r : d_r) << 16;
          quo_nxt = NW'(num);
          cnt_nxt = CW'(NW);
          acc_nxt = '0;
          state_nxt = S_DIV;
        end else begin
          rem2 = {acc_r, nq_r[VW-1 -: 2]};
          trial = VW'({root_r, 2'b01});
          alu_a = rem2[VW:0];
          alu_b = {1'b0, trial};
          alu_sub = 1'b1;
          nq_nxt = nq_r << 2;
          if (rem2[VW+1] || !alu_y[VW]) begin
            acc_nxt  = VW'(rem2 - (VW+2)'(trial));
            root_nxt = {root_r[RW-2:0], 1'b1};
          end else begin
            acc_nxt  = rem2[VW-1:0];
            root_nxt = {root_r[RW-2:0], 1'b0};
          end
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      S_DIV: begin
        // Restoring divide, one quotient bit a step: |num| / mplier.
        if (cnt_r == '0) begin
          if (quo_r > NW'(24'h800000)) begin
            oz_nxt = d_r[DW-1] ? rwz_pkg::ZMin : rwz_pkg::ZMax;
          end else begin
            oz_nxt = d_r[DW-1] ? XW'(-quo_r) : XW'(quo_r);
            if (!d_r[DW-1] && quo_r == NW'(24'h800000)) oz_nxt = rwz_pkg::ZMax;
          end
          state_nxt = S_DONE;
        end else begin
          rem2 = (VW+2)'({acc_r, quo_r[NW-1]});
          alu_a = rem2[VW:0];
          alu_b = {1'b0, mplier_r};
          alu_sub = 1'b1;
          if (!alu_y[VW]) begin
            acc_nxt = alu_y[VW-1:0];
            quo_nxt = {quo_r[NW-2:0], 1'b1};
          end else begin
            acc_nxt = rem2[VW-1:0];
            quo_nxt = {quo_r[NW-2:0], 1'b0};
          end
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      S_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
          cnt_nxt = '0;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and payload registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      cnt_r   <= '0;
      for (int i = 0; i < rwz_pkg::Channels; i++) begin
        fill_r[i]   <= '0;
        oldest_r[i] <= '0;
        sum_r[i]    <= '0;
        sq_r[i]     <= '0;
      end
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == S_AUPD && ch_ok) begin
        if (32'(n_cur) >= rwz_pkg::Window) begin
          oldest_r[ci] <= rwz_pkg::SlotW'(oldest_r[ci] + rwz_pkg::SlotW'(1));
          sum_r[ci] <= sum_r[ci] - rwz_pkg::SumW'(ring_rd_r) + rwz_pkg::SumW'(x_r);
          sq_r[ci]  <= sq_r[ci] - rwz_pkg::SqW'(ring_rd_r * ring_rd_r)
                       + rwz_pkg::SqW'(x_r * x_r);
        end else begin
          fill_r[ci] <= n_cur + rwz_pkg::FillW'(1);
          sum_r[ci]  <= sum_r[ci] + rwz_pkg::SumW'(x_r);
          sq_r[ci]   <= sq_r[ci] + rwz_pkg::SqW'(x_r * x_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_req_type;
      ch_r  <= in_channel;
      x_r   <= in_sample_value;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    nq_r     <= nq_nxt;
    root_r   <= root_nxt;
    quo_r    <= quo_nxt;
    d_r      <= d_nxt;
    oz_r     <= oz_nxt;
    ovf_r    <= ovf_nxt;
    oef_r    <= oef_nxt;
    if (state_r == S_DONE && (!ov_r || out_ready)) begin
      oc_r     <= ch_r;
      res_z_r  <= oz_r;
      res_vf_r <= ovf_r;
      res_ef_r <= oef_r;
    end
  end

  assign out_valid         = ov_r;
  assign out_channel       = oc_r;
  assign out_z_score       = res_z_r;
  assign out_variance_flag = res_vf_r;
  assign out_empty_flag    = res_ef_r;

  // Checks.
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_variance_flag && out_empty_flag))
    else $error("both result flags set");
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_flag) |-> out_z_score == '0)
    else $error("empty window gave nonzero score");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("ready while busy");
  a_add_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_AUPD && !req_r) |=> !$rose(out_valid))
    else $error("add produced a result");
endmodule

// ===== tb/sv/rolling_window_zscore_tb.sv =====
// Testbench for rolling_window_zscore: directed and random add/normalize traffic
// checked against a behavioral predictor in a small scoreboard class.
// Depends on rwz_pkg and the rolling_window_zscore RTL.
`timescale 1ns / 1ps
module rolling_window_zscore_tb;

  typedef struct packed {
    logic [rwz_pkg::ChW-1:0]       chan;
    logic signed [rwz_pkg::XW-1:0] z;
    logic                          var_flag;
    logic                          empty_flag;
  } zscore_t;

  int unsigned error_count = 0;

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what);
    $display("ERROR %0t: %s", $realtime, what);
    error_count++;
  endtask

  // Scoreboard: window state per channel and a ring of pending z-scores.
  class zscore_scoreboard;
    localparam int ExpDepth = 1024;
    logic signed [rwz_pkg::XW-1:0] ring [rwz_pkg::Channels][rwz_pkg::Window];
    int unsigned          fill [rwz_pkg::Channels];
    int unsigned          oldest [rwz_pkg::Channels];
    longint               sum [rwz_pkg::Channels];
    longint               sq_sum [rwz_pkg::Channels];
    zscore_t              expect_buf [ExpDepth];
    int unsigned          exp_wr;
    int unsigned          exp_rd;

    function new();
      for (int c = 0; c < rwz_pkg::Channels; c++) begin
        fill[c] = 0;
        oldest[c] = 0;
        sum[c] = 0;
        sq_sum[c] = 0;
      end
      exp_wr = 0;
      exp_rd = 0;
    endfunction

    // Number of predicted results not yet seen.
    function int unsigned outstanding();
      return exp_wr - exp_rd;
    endfunction

    // Integer square root, floor, of a 128-bit value below 2**82.
    function logic [63:0] floor_sqrt(input logic [127:0] v);
      logic [63:0]  r;
      logic [63:0]  c;
      logic [127:0] c2;
      r = 0;
      for (int b = 40; b >= 0; b--) begin
        c = r | (64'd1 << b);
        c2 = c * c;
        if (c2 <= v) r = c;
      end
      return r;
    endfunction

    // Apply an add to the window state, or queue a normalize prediction.
    function void note_input(logic req, logic [rwz_pkg::ChW-1:0] ch,
                             logic signed [rwz_pkg::XW-1:0] x);
      longint          n;
      longint          d;
      longint          xl;
      logic [127:0]    nq;
      logic [127:0]    ss;
      logic [63:0]     root;
      logic [127:0]    mag;
      longint          zl;
      logic [63:0]     sa;
      int unsigned     slot;
      zscore_t         r;
      xl = x;
      if (req == rwz_pkg::REQ_ADD) begin
        if (fill[ch] >= rwz_pkg::Window) begin
          slot = oldest[ch];
          sum[ch] -= ring[ch][slot];
          sq_sum[ch] -= longint'(ring[ch][slot]) * longint'(ring[ch][slot]);
          ring[ch][slot] = x;
          oldest[ch] = (slot + 1) % rwz_pkg::Window;
        end else begin
          ring[ch][(oldest[ch] + fill[ch]) % rwz_pkg::Window] = x;
          fill[ch]++;
        end
        sum[ch] += xl;
        sq_sum[ch] += xl * xl;
        return;
      end
      r = '0;
      r.chan = ch;
      if (fill[ch] == 0) begin
        r.empty_flag = 1'b1;
      end else begin
        n = fill[ch];
        d = n * xl - sum[ch];
        sa = sum[ch] < 0 ? -sum[ch] : sum[ch];
        nq = 128'(sq_sum[ch]) * 128'(n);
        ss = 128'(sa) * 128'(sa);
        if (nq <= ss) begin
          zl = d / n;
          r.var_flag = 1'b1;
        end else begin
          root = floor_sqrt(nq - ss);
          if (root == 0) root = 1;
          mag = 128'(d < 0 ? -d : d) * 128'd65536 / 128'(root);
          if (mag > 128'd16777216) mag = 128'd16777216;
          zl = d < 0 ? -longint'(mag) : longint'(mag);
        end
        if (zl > 8388607) zl = 8388607;
        if (zl < -8388608) zl = -8388608;
        r.z = zl[rwz_pkg::XW-1:0];
      end
      expect_buf[exp_wr % ExpDepth] = r;
      exp_wr++;
    endfunction

    // Compare an accepted result transfer with the oldest expectation.
    task check_result(zscore_t got);
      zscore_t exp_z;
      if (outstanding() == 0) begin
        report_mismatch($sformatf("unexpected result ch=%0d", got.chan));
        return;
      end
      exp_z = expect_buf[exp_rd % ExpDepth];
      exp_rd++;
      if (got.chan !== exp_z.chan)
        report_mismatch($sformatf("channel %0d, want %0d", got.chan, exp_z.chan));
      if (got.z !== exp_z.z)
        report_mismatch($sformatf("z_score %0d, want %0d (ch %0d)",
                                  got.z, exp_z.z, exp_z.chan));
      if (got.var_flag !== exp_z.var_flag)
        report_mismatch($sformatf("variance_flag %0b, want %0b", got.var_flag,
                                  exp_z.var_flag));
      if (got.empty_flag !== exp_z.empty_flag)
        report_mismatch($sformatf("empty_flag %0b, want %0b", got.empty_flag,
                                  exp_z.empty_flag));
    endtask
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          in_req_type = rwz_pkg::REQ_ADD;
  logic [rwz_pkg::ChW-1:0]       in_channel = '0;
  logic signed [rwz_pkg::XW-1:0] in_sample_value = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [rwz_pkg::ChW-1:0]       out_channel;
  logic signed [rwz_pkg::XW-1:0] out_z_score;
  logic                          out_variance_flag;
  logic                          out_empty_flag;

  zscore_scoreboard board = new();
  int unsigned      idle_cycles = 0;

  always #5 clk = ~clk;

  rolling_window_zscore dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_req_type, .in_channel,
    .in_sample_value, .out_valid, .out_ready, .out_channel, .out_z_score,
    .out_variance_flag, .out_empty_flag
  );

  // Half the time no gap, else mostly a short one, occasionally a long one.
  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  // Present one item at a falling edge and hold it until the transfer happens.
  // Called at a falling edge and returns at the falling edge after the transfer.
  task automatic send_item(input logic req, input logic [rwz_pkg::ChW-1:0] ch,
                           input logic signed [rwz_pkg::XW-1:0] x);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_channel <= ch;
    in_sample_value <= x;
    do @(posedge clk); while (!in_ready);
    board.note_input(req, ch, x);
    @(negedge clk);
  endtask

  // Random sample: full range, small values, extremes, or a repeat constant.
  function automatic logic signed [rwz_pkg::XW-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return rwz_pkg::ZMax;
      1: return rwz_pkg::ZMin;
      2: return $signed(24'($urandom_range(0, 2047)) - 24'd1024);
      3: return 24'sh010000;
      default: return 24'($urandom);
    endcase
  endfunction

  // Result side: random stalls, check at the rising edge on each transfer.
  initial begin
    int unsigned g;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      g = gap_len();
      if (g != 0) begin
        out_ready <= 1'b0;
        repeat (g) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_result('{out_channel, out_z_score, out_variance_flag, out_empty_flag});
    end
  end

  // Watchdog: cycles with no transfer on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("rolling_window_zscore test failed");
      $finish;
    end
  end

  initial begin
    logic [rwz_pkg::ChW-1:0] ch;
    int unsigned    k;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty window, single sample, constant window, extremes.
    send_item(rwz_pkg::REQ_NORM, 5'd0, rwz_pkg::ZMax);
    send_item(rwz_pkg::REQ_ADD, 5'd0, 24'sh010000);
    send_item(rwz_pkg::REQ_NORM, 5'd0, rwz_pkg::ZMin);
    send_item(rwz_pkg::REQ_ADD, 5'd0, 24'sh010000);
    send_item(rwz_pkg::REQ_NORM, 5'd0, 24'sh010000);
    send_item(rwz_pkg::REQ_ADD, 5'd31, rwz_pkg::ZMax);
    send_item(rwz_pkg::REQ_ADD, 5'd31, rwz_pkg::ZMin);
    send_item(rwz_pkg::REQ_NORM, 5'd31, rwz_pkg::ZMax);
    send_item(rwz_pkg::REQ_NORM, 5'd31, rwz_pkg::ZMin);
    send_item(rwz_pkg::REQ_NORM, 5'd31, 24'sh000000);
    send_item(rwz_pkg::REQ_ADD, 5'd1, 24'sh000000);
    send_item(rwz_pkg::REQ_ADD, 5'd1, 24'sh000001);
    send_item(rwz_pkg::REQ_NORM, 5'd1, rwz_pkg::ZMax);
    send_item(rwz_pkg::REQ_NORM, 5'd1, rwz_pkg::ZMin);
    send_item(rwz_pkg::REQ_NORM, 5'd17, 24'sh5A5A5A);

    // Random: fill channels past the window so wrap-around is exercised.
    for (int i = 0; i < 900; i++) begin
      k = $urandom_range(0, 99);
      ch = (k < 80) ? 5'($urandom_range(0, 3)) : 5'($urandom);
      if (k < 55) send_item(rwz_pkg::REQ_ADD, ch, rand_sample());
      else send_item(rwz_pkg::REQ_NORM, ch, rand_sample());
    end
    in_valid <= 1'b0;

    while (board.outstanding() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0 && board.outstanding() == 0) begin
      $display("rolling_window_zscore test passed");
    end else begin
      $display("rolling_window_zscore test failed");
    end
    $finish;
  end
endmodule
